>>> design/verlet_particle_update_top_macros.svh
// verlet_particle_update_top_macros.svh
// Assertion macros for the particle update checker; they expect signals named
// clk and rst_n in the scope where they are used.
`ifndef VERLET_PARTICLE_UPDATE_TOP_MACROS_SVH
`define VERLET_PARTICLE_UPDATE_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define VPU_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define VPU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that is also checked across reset.
`define VPU_ASSERT_RST(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/vpu_pkg.sv
// vpu_pkg.sv
// Widths, register codes, payload structs and helper functions of the particle update block.
// No dependencies; used by the top level and the checker.
package vpu_pkg;

  localparam int FRAC_BITS = 16;
  localparam int DW        = 32;
  localparam int DTW       = 21;
  localparam int WW        = 31;
  localparam int CFG_AW    = 3;

  localparam int IN_TDATA_W  = 7 * DW;
  localparam int OUT_TDATA_W = 9 * DW;

  // Product and rounding widths of the two integration terms.
  localparam int P1W = DW + DTW + 1;
  localparam int R1W = P1W - FRAC_BITS;
  localparam int P2W = R1W + DTW + 1;
  localparam int R2W = P2W - FRAC_BITS;
  localparam int SW  = R2W + 2;
  localparam int HALF = 1 << (FRAC_BITS - 1);

  // Divider: quotient bits produced per pipeline stage.
  localparam int DIV_STEPS  = 2;
  localparam int DIV_STAGES = DW / DIV_STEPS;
  localparam int NSTG       = 5 + DIV_STAGES + 2;

  localparam int SQW  = 2 * DW;
  localparam int LENW = SQW + 1;
  localparam logic [LENW-1:0] SPEED_LIMIT = LENW'(4) << (2 * FRAC_BITS);
  localparam int SPRING_SHIFT = 3;

  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  localparam logic [DTW-1:0] TIME_STEP_RST  = DTW'(655);
  localparam logic [WW-1:0]  HALF_WIDTH_RST = WW'(6553600);

  localparam logic signed [DW-1:0] SMAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] SMIN = {1'b1, {(DW-1){1'b0}}};

  typedef enum logic [CFG_AW-1:0] {
    REG_TIME_STEP  = 3'd0,
    REG_HALF_WIDTH = 3'd1,
    REG_FLOOR      = 3'd2,
    REG_GRAV_X     = 3'd3,
    REG_GRAV_Y     = 3'd4,
    REG_AGING      = 3'd5
  } cfg_reg_t;

  // Fields that ride along the front of the pipeline.
  typedef struct packed {
    logic signed [DW-1:0] px;
    logic signed [DW-1:0] py;
    logic signed [DW-1:0] life;
    logic                 rm;
  } carry_t;

  // Fields that ride along the divider.
  typedef struct packed {
    logic signed [DW-1:0] nx;
    logic signed [DW-1:0] ny;
    logic signed [DW-1:0] px;
    logic signed [DW-1:0] py;
    logic signed [DW-1:0] gfx;
    logic signed [DW-1:0] gfy;
    logic signed [DW-1:0] life;
    logic                 rm;
  } pass_t;

  // Partial remainder, dividend bits still to shift in with quotient bits
  // shifting in behind them, sign of the difference and quotient overflow.
  typedef struct packed {
    logic [DTW-1:0] rem;
    logic [DW-1:0]  nq;
    logic           neg;
    logic           ovf;
  } div_t;

  typedef struct packed {
    logic signed [DW-1:0] nx;
    logic signed [DW-1:0] ny;
    logic signed [DW-1:0] px;
    logic signed [DW-1:0] py;
    logic signed [DW-1:0] vx;
    logic signed [DW-1:0] vy;
    logic signed [DW-1:0] gfx;
    logic signed [DW-1:0] gfy;
    logic signed [DW-1:0] life;
    logic                 rm;
  } res_t;

  // Saturate a wide signed value to DW bits.
  function automatic logic signed [DW-1:0] sat_dw(input logic signed [SW-1:0] v);
    logic signed [DW-1:0] r;
    if ((v[SW-1:DW-1] == '0) || (v[SW-1:DW-1] == '1)) begin
      r = v[DW-1:0];
    end else if (v[SW-1]) begin
      r = SMIN;
    end else begin
      r = SMAX;
    end
    return r;
  endfunction

  // DIV_STEPS restoring division steps.
  function automatic div_t div_stage(input div_t d, input logic [DTW-1:0] dv);
    div_t       r;
    logic [DTW:0] t;
    logic       q;
    r = d;
    for (int i = 0; i < DIV_STEPS; i++) begin
      t = {r.rem, r.nq[DW-1]};
      q = (t >= {1'b0, dv});
      if (q) begin
        t = t - {1'b0, dv};
      end
      r.rem = t[DTW-1:0];
      r.nq  = {r.nq[DW-2:0], q};
    end
    return r;
  endfunction

  // Apply sign and saturation to an unsigned quotient.
  function automatic logic signed [DW-1:0] vel_fix(input div_t d, input logic dt_zero);
    logic signed [DW-1:0] r;
    if (dt_zero) begin
      r = '0;
    end else if (!d.neg) begin
      r = (d.ovf || d.nq[DW-1]) ? SMAX : $signed(d.nq);
    end else if (d.ovf || (d.nq[DW-1] && (|d.nq[DW-2:0]))) begin
      r = SMIN;
    end else begin
      r = $signed(DW'(0) - d.nq);
    end
    return r;
  endfunction

endpackage

>>> design/verlet_particle_update_top.sv
// verlet_particle_update_top.sv
// Position-Verlet update of one 2D particle per transfer, fully pipelined.
// Depends on vpu_pkg.
//
// One particle transfer is accepted per clock cycle while the output queue
// has room. The pipeline is built around the quotient divider for the derived
// velocity, which yields two quotient bits in each of its 16 stages, plus
// four stages of multiply and round and a divider setup stage in front of it
// and two stages of saturation and speed test behind it. Every stage advances
// together; a two-entry output queue keeps the input open while a finished
// result waits, and the pipeline pauses only when that queue holds two
// results. A result taken from a full queue does not reopen the input in the
// same cycle. Configuration writes take effect at once and are meant to be
// made only while no particle is in flight. All particle fields are signed
// Q16.16; positions, velocities, forces and lifetimes saturate to 32 bits.
module verlet_particle_update_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // Fields from bit 0: pos_x, pos_y, vel_x, vel_y, force_x, force_y, life_left.
  input  logic [vpu_pkg::IN_TDATA_W-1:0]      in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // Fields from bit 0: next_pos_x, next_pos_y, prev_pos_x, prev_pos_y,
  // next_vel_x, next_vel_y, next_force_x, next_force_y, next_life.
  output logic [vpu_pkg::OUT_TDATA_W-1:0]     out_tdata,
  // Fields from bit 0: remove_flag.
  output logic                                out_tuser,
  input  logic                                cfg_we,
  input  logic [vpu_pkg::CFG_AW-1:0]          cfg_addr,
  input  logic [vpu_pkg::DW-1:0]              cfg_wdata
);
  import vpu_pkg::*;

  // Configuration registers.
  logic [DTW-1:0]        time_step_r;
  logic [WW-1:0]         half_width_r;
  logic signed [DW-1:0]  floor_r;
  logic signed [DW-1:0]  grav_x_r;
  logic signed [DW-1:0]  grav_y_r;
  logic                  aging_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_step_r  <= TIME_STEP_RST;
      half_width_r <= HALF_WIDTH_RST;
      floor_r      <= '0;
      grav_x_r     <= '0;
      grav_y_r     <= '0;
      aging_r      <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_addr))
        REG_TIME_STEP:  time_step_r  <= cfg_wdata[DTW-1:0];
        REG_HALF_WIDTH: half_width_r <= cfg_wdata[WW-1:0];
        REG_FLOOR:      floor_r      <= $signed(cfg_wdata);
        REG_GRAV_X:     grav_x_r     <= $signed(cfg_wdata);
        REG_GRAV_Y:     grav_y_r     <= $signed(cfg_wdata);
        REG_AGING:      aging_r      <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  logic signed [DTW:0] dt_s;
  logic                dt_zero;
  assign dt_s    = $signed({1'b0, time_step_r});
  assign dt_zero = (time_step_r == '0);

  // Pipeline control: all stages move together whenever the output queue has
  // room. A valid bit travels with every stage.
  logic                  en;
  logic [NSTG-1:0]       vld_r;
  logic                  push;
  logic                  pop;
  logic [FIFO_CW-1:0]    cnt_r;

  assign en        = (cnt_r != FIFO_CW'(FIFO_DEPTH));
  assign in_tready = en;
  assign push      = en && vld_r[NSTG-1];
  assign pop       = out_tvalid && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NSTG-2:0], in_tvalid};
    end
  end

  // Input fields.
  logic signed [DW-1:0] in_px, in_py, in_vx, in_vy, in_fx, in_fy, in_life;
  assign in_px   = $signed(in_tdata[0*DW +: DW]);
  assign in_py   = $signed(in_tdata[1*DW +: DW]);
  assign in_vx   = $signed(in_tdata[2*DW +: DW]);
  assign in_vy   = $signed(in_tdata[3*DW +: DW]);
  assign in_fx   = $signed(in_tdata[4*DW +: DW]);
  assign in_fy   = $signed(in_tdata[5*DW +: DW]);
  assign in_life = $signed(in_tdata[6*DW +: DW]);

  // Stage 1: vel*dt and force*dt products; lifetime update.
  logic signed [P1W-1:0] prod_vx, prod_vy, prod_fx, prod_fy;
  logic signed [SW-1:0]  life_dec;
  logic signed [DW-1:0]  life_sat;
  carry_t                s1_carry;

  assign prod_vx  = P1W'(in_vx) * P1W'(dt_s);
  assign prod_vy  = P1W'(in_vy) * P1W'(dt_s);
  assign prod_fx  = P1W'(in_fx) * P1W'(dt_s);
  assign prod_fy  = P1W'(in_fy) * P1W'(dt_s);
  assign life_dec = SW'(in_life) - SW'(dt_s);
  assign life_sat = sat_dw(life_dec);

  always_comb begin
    s1_carry.px   = in_px;
    s1_carry.py   = in_py;
    s1_carry.life = aging_r ? life_sat : in_life;
    s1_carry.rm   = aging_r && life_sat[DW-1];
  end

  logic signed [P1W-1:0] s1_vdx_r, s1_vdy_r, s1_fdx_r, s1_fdy_r;
  carry_t                s1_c_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s1_vdx_r <= prod_vx;
      s1_vdy_r <= prod_vy;
      s1_fdx_r <= prod_fx;
      s1_fdy_r <= prod_fy;
      s1_c_r   <= s1_carry;
    end
  end

  // Stage 2: round both products to nearest, ties upward.
  logic signed [P1W-1:0] vdx_h, vdy_h, fdx_h, fdy_h;
  assign vdx_h = s1_vdx_r + P1W'(HALF);
  assign vdy_h = s1_vdy_r + P1W'(HALF);
  assign fdx_h = s1_fdx_r + P1W'(HALF);
  assign fdy_h = s1_fdy_r + P1W'(HALF);

  logic signed [R1W-1:0] s2_vrx_r, s2_vry_r, s2_frx_r, s2_fry_r;
  carry_t                s2_c_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s2_vrx_r <= vdx_h[P1W-1:FRAC_BITS];
      s2_vry_r <= vdy_h[P1W-1:FRAC_BITS];
      s2_frx_r <= fdx_h[P1W-1:FRAC_BITS];
      s2_fry_r <= fdy_h[P1W-1:FRAC_BITS];
      s2_c_r   <= s2_c_r == s2_c_r ? s1_c_r : s1_c_r;
    end
  end

  // Stage 3: second multiply by dt for the force term.
  logic signed [R1W-1:0] s3_vrx_r, s3_vry_r;
  logic signed [P2W-1:0] s3_f2x_r, s3_f2y_r;
  carry_t                s3_c_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s3_vrx_r <= s2_vrx_r;
      s3_vry_r <= s2_vry_r;
      s3_f2x_r <= P2W'(s2_frx_r) * P2W'(dt_s);
      s3_f2y_r <= P2W'(s2_fry_r) * P2W'(dt_s);
      s3_c_r   <= s2_c_r;
    end
  end

  // Stage 4: round the force term and sum the new position with saturation.
  logic signed [P2W-1:0] f2x_h, f2y_h;
  logic signed [R2W-1:0] f2x_rnd, f2y_rnd;
  logic signed [SW-1:0]  sum_x, sum_y;

  assign f2x_h   = s3_f2x_r + P2W'(HALF);
  assign f2y_h   = s3_f2y_r + P2W'(HALF);
  assign f2x_rnd = f2x_h[P2W-1:FRAC_BITS];
  assign f2y_rnd = f2y_h[P2W-1:FRAC_BITS];
  assign sum_x   = SW'(s3_c_r.px) + SW'(s3_vrx_r) + SW'(f2x_rnd);
  assign sum_y   = SW'(s3_c_r.py) + SW'(s3_vry_r) + SW'(f2y_rnd);

  logic signed [DW-1:0] s4_nx_r, s4_ny_r;
  carry_t               s4_c_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s4_nx_r <= sat_dw(sum_x);
      s4_ny_r <= sat_dw(sum_y);
      s4_c_r  <= s3_c_r;
    end
  end

  // Stage 5: divider setup for the displacement and wall springs.
  // The quotient |diff| * 2^FRAC / dt overflows 32 bits exactly when
  // |diff| >= dt * 2^(32-FRAC); the dividend bits above bit 31 seed the
  // partial remainder.
  logic signed [DW:0]    diff_x, diff_y, mdx, mdy;
  logic [DW-1:0]         mag_x, mag_y;
  logic [DW+DTW-1:0]     dt_sh;
  div_t                  div_x, div_y;

  assign diff_x = {s4_nx_r[DW-1], s4_nx_r} - {s4_c_r.px[DW-1], s4_c_r.px};
  assign diff_y = {s4_ny_r[DW-1], s4_ny_r} - {s4_c_r.py[DW-1], s4_c_r.py};
  assign mdx    = diff_x[DW] ? -diff_x : diff_x;
  assign mdy    = diff_y[DW] ? -diff_y : diff_y;
  assign mag_x  = mdx[DW-1:0];
  assign mag_y  = mdy[DW-1:0];
  assign dt_sh  = (DW+DTW)'(time_step_r) << (DW - FRAC_BITS);

  always_comb begin
    div_x.neg = diff_x[DW];
    div_x.ovf = ((DW+DTW)'(mag_x) >= dt_sh);
    div_x.rem = DTW'(mag_x >> (DW - FRAC_BITS));
    div_x.nq  = mag_x << FRAC_BITS;
    div_y.neg = diff_y[DW];
    div_y.ovf = ((DW+DTW)'(mag_y) >= dt_sh);
    div_y.rem = DTW'(mag_y >> (DW - FRAC_BITS));
    div_y.nq  = mag_y << FRAC_BITS;
  end

  // Each wall pushes back with one eighth of the distance beyond it. The
  // side walls exclude each other; floor and ceiling may both apply.
  logic signed [SW-1:0] w_s, nx_s, ny_s, fl_s;
  logic signed [SW-1:0] ex_l, ex_r, ex_f, ex_c;
  logic                 hit_l, hit_r, hit_f, hit_c;
  logic signed [SW-1:0] gfx_sum, gfy_sum;

  assign w_s  = $signed(SW'({1'b0, half_width_r}));
  assign nx_s = SW'(s4_nx_r);
  assign ny_s = SW'(s4_ny_r);
  assign fl_s = SW'(floor_r);
  assign ex_l = nx_s + w_s;
  assign ex_r = nx_s - w_s;
  assign ex_f = ny_s - fl_s;
  assign ex_c = ny_s - (w_s <<< 1);
  assign hit_l = ex_l[SW-1];
  assign hit_r = !ex_r[SW-1] && (ex_r != '0);
  assign hit_f = ex_f[SW-1];
  assign hit_c = !ex_c[SW-1] && (ex_c != '0);

  assign gfx_sum = SW'(grav_x_r)
                 - (hit_l ? (ex_l >>> SPRING_SHIFT) : SW'(0))
                 - (hit_r ? (ex_r >>> SPRING_SHIFT) : SW'(0));
  assign gfy_sum = SW'(grav_y_r)
                 - (hit_f ? (ex_f >>> SPRING_SHIFT) : SW'(0))
                 - (hit_c ? (ex_c >>> SPRING_SHIFT) : SW'(0));

  pass_t s5_pass;
  always_comb begin
    s5_pass.nx   = s4_nx_r;
    s5_pass.ny   = s4_ny_r;
    s5_pass.px   = s4_c_r.px;
    s5_pass.py   = s4_c_r.py;
    s5_pass.gfx  = sat_dw(gfx_sum);
    s5_pass.gfy  = sat_dw(gfy_sum);
    s5_pass.life = s4_c_r.life;
    s5_pass.rm   = s4_c_r.rm;
  end

  pass_t s5_p_r;
  div_t  s5_dx_r, s5_dy_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s5_p_r  <= s5_pass;
      s5_dx_r <= div_x;
      s5_dy_r <= div_y;
    end
  end

  // Divider stages: DIV_STEPS quotient bits per stage for each axis.
  pass_t dv_p_r [DIV_STAGES];
  div_t  dv_x_r [DIV_STAGES];
  div_t  dv_y_r [DIV_STAGES];

  always_ff @(posedge clk) begin
    if (en) begin
      dv_p_r[0] <= s5_p_r;
      dv_x_r[0] <= div_stage(s5_dx_r, time_step_r);
      dv_y_r[0] <= div_stage(s5_dy_r, time_step_r);
      for (int k = 1; k < DIV_STAGES; k++) begin
        dv_p_r[k] <= dv_p_r[k-1];
        dv_x_r[k] <= div_stage(dv_x_r[k-1], time_step_r);
        dv_y_r[k] <= div_stage(dv_y_r[k-1], time_step_r);
      end
    end
  end

  // Stage 6: sign and saturation of the velocity.
  pass_t                s6_p_r;
  logic signed [DW-1:0] s6_vx_r, s6_vy_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s6_p_r  <= dv_p_r[DIV_STAGES-1];
      s6_vx_r <= vel_fix(dv_x_r[DIV_STAGES-1], dt_zero);
      s6_vy_r <= vel_fix(dv_y_r[DIV_STAGES-1], dt_zero);
    end
  end

  // Stage 7: squares for the speed test.
  pass_t                 s7_p_r;
  logic signed [DW-1:0]  s7_vx_r, s7_vy_r;
  logic signed [SQW-1:0] s7_sqx_r, s7_sqy_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s7_p_r   <= s6_p_r;
      s7_vx_r  <= s6_vx_r;
      s7_vy_r  <= s6_vy_r;
      s7_sqx_r <= SQW'(s6_vx_r) * SQW'(s6_vx_r);
      s7_sqy_r <= SQW'(s6_vy_r) * SQW'(s6_vy_r);
    end
  end

  // Halve the velocity when its squared length exceeds 4.0.
  logic [LENW-1:0] len2;
  logic            too_fast;
  res_t            push_data;

  assign len2     = {1'b0, s7_sqx_r} + {1'b0, s7_sqy_r};
  assign too_fast = (len2 > SPEED_LIMIT);

  always_comb begin
    push_data.nx   = s7_p_r.nx;
    push_data.ny   = s7_p_r.ny;
    push_data.px   = s7_p_r.px;
    push_data.py   = s7_p_r.py;
    push_data.vx   = too_fast ? (s7_vx_r >>> 1) : s7_vx_r;
    push_data.vy   = too_fast ? (s7_vy_r >>> 1) : s7_vy_r;
    push_data.gfx  = s7_p_r.gfx;
    push_data.gfy  = s7_p_r.gfy;
    push_data.life = s7_p_r.life;
    push_data.rm   = s7_p_r.rm;
  end

  // Output queue: two entries, so a single waiting result never blocks the input.
  res_t               ent_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, rd_ptr_r;
  res_t               head;

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + FIFO_AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + FIFO_AW'(1);
      end
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + FIFO_CW'(1);
        2'b01:   cnt_r <= cnt_r - FIFO_CW'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  assign head       = ent_r[rd_ptr_r];
  assign out_tvalid = (cnt_r != '0);
  assign out_tdata  = {head.life, head.gfy, head.gfx, head.vy, head.vx,
                       head.py, head.px, head.ny, head.nx};
  assign out_tuser  = head.rm;

endmodule

>>> design/vpu_checker.sv
// vpu_checker.sv
// Port-level assertions for the particle update block, bound to its top level.
// Depends on vpu_pkg and verlet_particle_update_top_macros.svh.
`include "verlet_particle_update_top_macros.svh"

module vpu_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic [vpu_pkg::IN_TDATA_W-1:0]  in_tdata,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [vpu_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                            out_tuser,
  input logic                            cfg_we,
  input logic [vpu_pkg::CFG_AW-1:0]      cfg_addr,
  input logic [vpu_pkg::DW-1:0]          cfg_wdata
);
  import vpu_pkg::*;

  localparam int OSW = $clog2(NSTG + FIFO_DEPTH + 2);

  logic           in_xfer, out_xfer;
  logic [OSW-1:0] outst_r;

  assign in_xfer  = in_tvalid && in_tready;
  assign out_xfer = out_tvalid && out_tready;

  // Particles accepted but not yet delivered.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      outst_r <= '0;
    end else begin
      case ({in_xfer, out_xfer})
        2'b10:   outst_r <= outst_r + OSW'(1);
        2'b01:   outst_r <= outst_r - OSW'(1);
        default: outst_r <= outst_r;
      endcase
    end
  end

  `VPU_ASSERT_RST(a_empty_after_reset, !rst_n, !out_tvalid, "result offered right after reset")
  `VPU_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser), "stalled result changed")
  `VPU_ASSERT_NOW(a_no_extra_result, out_tvalid, outst_r != '0, "result without an accepted particle")
  `VPU_ASSERT_NOW(a_remove_needs_neg_life, out_tvalid && out_tuser, out_tdata[OUT_TDATA_W-1], "remove flag with non-negative lifetime")

endmodule

bind verlet_particle_update_top vpu_checker u_vpu_checker (.*);
